/* hdl/wmh_pkg.sv */
package wmh_pkg;

  localparam int NUM_BINS = 16;
  localparam int BIN_W    = 4;
  localparam int AMT_W    = 64;
  localparam int STAT_W   = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic REG_DEFAULT_BIN = 1'b0;

  localparam logic [STAT_W-1:0] STAT_FOUND   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEFAULT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HALF,
    S_SCAN,
    S_DONE
  } wmh_state_t;

  typedef struct packed {
    logic             vld;
    logic             found;
    logic [BIN_W-1:0] fidx;
    logic [AMT_W-1:0] run;
  } wmh_tok_t;

endpackage

/* hdl/wmh_cell.sv */
module wmh_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wmh_pkg::BIN_W-1:0]  cell_idx,
  input  logic                       upd_en,
  input  logic [wmh_pkg::BIN_W-1:0]  upd_bin,
  input  logic [wmh_pkg::AMT_W-1:0]  upd_amount,
  input  logic [wmh_pkg::AMT_W-1:0]  half,
  input  wmh_pkg::wmh_tok_t          tok_in,
  output wmh_pkg::wmh_tok_t          tok_out
);
  import wmh_pkg::*;

  logic [AMT_W-1:0] tally_r, tally_nxt;
  wmh_tok_t         tok_r, tok_nxt;
  logic [AMT_W-1:0] run_sum;
  logic             reach;

  always_comb begin
    tally_nxt = tally_r;
    if (upd_en && (upd_bin == cell_idx)) begin
      tally_nxt = tally_r + upd_amount;
    end
  end

  assign run_sum = tok_in.run + tally_r;
  assign reach   = ($signed(run_sum) >= $signed(half));

  always_comb begin
    tok_nxt.vld   = tok_in.vld;
    tok_nxt.run   = run_sum;
    tok_nxt.found = tok_in.found | reach;
    tok_nxt.fidx  = tok_in.found ? tok_in.fidx : cell_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      tok_r   <= '0;
    end else begin
      tally_r <= tally_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* hdl/weighted_median_histogram_top.sv */
// A reported item goes through S_HALF, which registers half the total, and
// S_SCAN, where the prefix scan walks the 16-cell chain one cell per cycle; a
// zero total skips S_SCAN. No new item is taken until S_DONE hands the result
// on; items without a report are taken every cycle while no report is pending.
// Reset (synchronous, active low) clears all bin tallies, the total and
// default_bin.
module weighted_median_histogram_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wmh_pkg::BIN_W-1:0]   in_bin,
  input  logic signed [wmh_pkg::AMT_W-1:0] in_amount,
  input  logic                        in_report,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wmh_pkg::BIN_W-1:0]   out_median_bin,
  output logic [wmh_pkg::STAT_W-1:0]  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wmh_pkg::CFG_AW-1:0]  paddr,
  input  logic [wmh_pkg::CFG_DW-1:0]  pwdata,
  output logic [wmh_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import wmh_pkg::*;

  wmh_state_t         state_r, state_nxt;
  logic [AMT_W-1:0]   total_r, total_nxt;
  logic [AMT_W-1:0]   half_r, half_nxt;
  logic               launch_r, launch_nxt;
  logic [BIN_W-1:0]   dflt_r, dflt_nxt;
  logic [BIN_W-1:0]   res_bin_r, res_bin_nxt;
  logic [STAT_W-1:0]  res_stat_r, res_stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]   out_bin_r, out_bin_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic               in_xfer;
  logic               in_range;
  logic               upd_en;
  logic               total_zero;
  logic               load_out;
  logic               cfg_wr;
  wmh_tok_t           chain [NUM_BINS+1];

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_xfer  = in_valid & ~in_stall;
  assign in_range = (32'(in_bin) < 32'(NUM_BINS));
  assign upd_en   = in_xfer & in_range;
  assign total_zero = (total_r == '0);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEFAULT_BIN) begin
      prdata = {{(CFG_DW-BIN_W){1'b0}}, dflt_r};
    end
  end

  always_comb begin
    dflt_nxt = dflt_r;
    if (cfg_wr && (paddr[2] == REG_DEFAULT_BIN)) begin
      dflt_nxt = pwdata[BIN_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_report) state_nxt = S_HALF;
      end
      S_HALF: begin
        state_nxt = total_zero ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (chain[NUM_BINS].vld) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    launch_nxt = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_HALF: launch_nxt = ~total_zero;
      S_SCAN: ;
      S_DONE: load_out = ~out_valid_r | ~out_stall;
      default: ;
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    if (upd_en) total_nxt = total_r + in_amount;
  end

  assign half_nxt = (state_r == S_HALF)
                  ? AMT_W'($signed(total_r + {{(AMT_W-1){1'b0}}, total_r[AMT_W-1]}) >>> 1)
                  : half_r;

  always_comb begin
    res_bin_nxt  = res_bin_r;
    res_stat_nxt = res_stat_r;
    if ((state_r == S_HALF) && total_zero) begin
      res_bin_nxt  = dflt_r;
      res_stat_nxt = STAT_DEFAULT;
    end else if ((state_r == S_SCAN) && chain[NUM_BINS].vld) begin
      res_bin_nxt  = chain[NUM_BINS].found ? chain[NUM_BINS].fidx : '0;
      res_stat_nxt = chain[NUM_BINS].found ? STAT_FOUND : STAT_NONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_bin_nxt   = out_bin_r;
    out_stat_nxt  = out_stat_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_bin_nxt   = res_bin_r;
      out_stat_nxt  = res_stat_r;
    end
  end

  always_comb begin
    chain[0].vld   = launch_r;
    chain[0].found = 1'b0;
    chain[0].fidx  = '0;
    chain[0].run   = '0;
  end

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    wmh_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (BIN_W'(i)),
      .upd_en     (upd_en),
      .upd_bin    (in_bin),
      .upd_amount (in_amount),
      .half       (half_r),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      launch_r    <= 1'b0;
      dflt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      launch_r    <= launch_nxt;
      dflt_r      <= dflt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r     <= half_nxt;
    res_bin_r  <= res_bin_nxt;
    res_stat_r <= res_stat_nxt;
    out_bin_r  <= out_bin_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_median_bin = out_bin_r;
  assign out_status     = out_stat_r;

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wmh_pkg::*;

  localparam logic [AMT_W-1:0] MAXV = 64'h7fff_ffff_ffff_ffff;
  localparam logic [AMT_W-1:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [CFG_AW-1:0] DFLT_ADDR = CFG_AW'(4 * int'(REG_DEFAULT_BIN));
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [STAT_W-1:0] status;
  } median_t;

  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [AMT_W-1:0]  amount;
    logic              report;
    bit                typed;
    logic [BIN_W-1:0]  want_bin;
    logic [STAT_W-1:0] want_status;
  } dir_row_t;

  localparam int NUM_ROWS = 20;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{4'd0,  64'd0,                  1'b1, 1'b1, 4'd0,  STAT_DEFAULT},
    '{4'd15, 64'd5,                  1'b1, 1'b1, 4'd15, STAT_FOUND},
    '{4'd15, -64'sd5,                1'b1, 1'b1, 4'd0,  STAT_DEFAULT},
    '{4'd0,  MAXV,                   1'b1, 1'b1, 4'd0,  STAT_FOUND},
    '{4'd0,  MINV,                   1'b1, 1'b1, 4'd0,  STAT_NONE},
    '{4'd0,  64'd1,                  1'b0, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd7,  -64'sd3,                1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd7,  64'd3,                  1'b0, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd3,  MINV,                   1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd3,  MINV,                   1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd5,  64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd10, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd5,  64'h5555_5555_5555_5556, 1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd10, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd1,  MAXV,                   1'b0, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd2,  MAXV,                   1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd14, 64'd1,                  1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd8,  MINV,                   1'b1, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd9,  -64'sd100,              1'b0, 1'b0, 4'd0,  STAT_FOUND},
    '{4'd9,  64'd100,                1'b1, 1'b0, 4'd0,  STAT_FOUND}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [BIN_W-1:0]         in_bin;
  logic signed [AMT_W-1:0]  in_amount;
  logic                     in_report;
  logic                     out_valid;
  logic                     out_stall;
  logic [BIN_W-1:0]         out_median_bin;
  logic [STAT_W-1:0]        out_status;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_AW-1:0]        paddr;
  logic [CFG_DW-1:0]        pwdata;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;

  logic [AMT_W-1:0] tally [NUM_BINS];
  logic [AMT_W-1:0] total_w;
  logic [BIN_W-1:0] dflt_bin;

  median_t median_q [$];
  int      mismatches;
  bit      quiet;
  bit      hold_req;
  int      pressure_left;

  weighted_median_histogram_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bin        (in_bin),
    .in_amount     (in_amount),
    .in_report     (in_report),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_median_bin(out_median_bin),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic bit update_histogram(input logic [BIN_W-1:0] b,
                                          input logic [AMT_W-1:0] amt,
                                          input logic rep,
                                          output median_t res);
    logic [AMT_W-1:0] half;
    logic [AMT_W-1:0] mag;
    logic [AMT_W-1:0] run;
    bit               hit;
    res = '0;
    if (int'(b) < NUM_BINS) begin
      tally[b] = tally[b] + amt;
      total_w  = total_w + amt;
    end
    if (!rep) return 1'b0;
    if (total_w == '0) begin
      res.bin    = dflt_bin;
      res.status = STAT_DEFAULT;
      return 1'b1;
    end
    if (total_w[AMT_W-1]) begin
      mag  = (64'd0 - total_w) >> 1;
      half = 64'd0 - mag;
    end else begin
      half = total_w >> 1;
    end
    run        = '0;
    hit        = 1'b0;
    res.status = STAT_NONE;
    for (int i = 0; i < NUM_BINS; i++) begin
      run = run + tally[i];
      if (!hit && $signed(run) >= $signed(half)) begin
        hit        = 1'b1;
        res.bin    = BIN_W'(i);
        res.status = STAT_FOUND;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [AMT_W-1:0] rand_amount(input logic [BIN_W-1:0] b);
    logic [AMT_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = 64'($urandom_range(1, 100));
      5: v = 64'd0 - 64'($urandom_range(1, 100));
      6: v = {$urandom, $urandom};
      7: begin
        case ($urandom_range(0, 3))
          0: v = MAXV;
          1: v = MINV;
          2: v = '1;
          default: v = '0;
        endcase
      end
      8: v = 64'd0 - tally[b];
      default: v = {24'd0, $urandom, 8'($urandom)};
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_item(input logic [BIN_W-1:0] b, input logic [AMT_W-1:0] amt,
                           input logic rep, input bit typed, input median_t want);
    int      gap;
    median_t res;
    gap = (quiet || pressure_left > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_bin    <= b;
    in_amount <= amt;
    in_report <= rep;
    do @(posedge clk); while (in_stall);
    if (update_histogram(b, amt, rep, res)) begin
      median_q.push_back(typed ? want : res);
    end
  endtask

  task automatic write_default_bin(input logic [BIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DFLT_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dflt_bin = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(dflt_bin)) begin
      $error("default_bin readback: expected %0d, got %0d", dflt_bin, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    median_t want;
    out_stall  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          $error("result transfer with no expected result: bin %0d status %0d",
                 out_median_bin, out_status);
          mismatches++;
        end else begin
          want = median_q.pop_front();
          if (out_median_bin !== want.bin) begin
            $error("median_bin: expected %0d, got %0d", want.bin, out_median_bin);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (quiet || $urandom_range(0, 99) < 75) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 40);
      end
    end
  end

  initial begin
    logic [BIN_W-1:0] phase_dflt [5];
    logic [BIN_W-1:0] b;
    logic [AMT_W-1:0] amt;
    logic             rep;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_bin    <= '0;
    in_amount <= '0;
    in_report <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    mismatches    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    pressure_left = 0;
    total_w       = '0;
    dflt_bin      = '0;
    foreach (tally[i]) tally[i] = '0;
    phase_dflt = '{4'd0, 4'd15, 4'd0, BIN_W'($urandom_range(1, 14)), 4'd7};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].bin, dir_rows[i].amount, dir_rows[i].report, dir_rows[i].typed,
                '{dir_rows[i].want_bin, dir_rows[i].want_status});
    end

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_default_bin(phase_dflt[p]);
        @(posedge clk);
      end
      if (p == 1) begin
        hold_req      = 1'b1;
        pressure_left = 40;
      end
      for (int k = 0; k < 80; k++) begin
        quiet = (k >= 20 && k < 40);
        b     = BIN_W'($urandom_range(0, NUM_BINS - 1));
        amt   = rand_amount(b);
        rep   = $urandom_range(0, 1);
        if (pressure_left > 0) rep = 1'b1;
        send_item(b, amt, rep, 1'b0, '0);
        if (pressure_left > 0) pressure_left--;
      end
      quiet = 1'b0;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
